[src/matrix3x3_inverse_unit_defines.svh]
// Assertion macros for the 3x3 matrix inverse unit.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef MATRIX3X3_INVERSE_UNIT_DEFINES_SVH
`define MATRIX3X3_INVERSE_UNIT_DEFINES_SVH

// same-cycle implication
`define M3INV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define M3INV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/m3inv_pkg.sv]
// Shared constants for the 3x3 matrix inverse unit.
// No dependencies.
package m3inv_pkg;
	localparam int MAT_DIM   = 3;
	localparam int NUM_ELEMS = MAT_DIM * MAT_DIM;
endpackage

[src/matrix3x3_inverse_unit.sv]
// 3x3 matrix inverse (adjugate over determinant), signed fixed point, saturated.
// Seven arithmetic stages, one restoring-division stage per quotient bit and one
// output stage. Throughput one matrix per cycle while the output is not
// stalled; bubbles close up when the output stalls.
// Reset (arst_n, asynchronous) clears only the per-stage valid bits.
// Depends on m3inv_pkg and matrix3x3_inverse_unit_defines.svh.
`include "matrix3x3_inverse_unit_defines.svh"

module matrix3x3_inverse_unit #(
	parameter int ELEMENT_WIDTH = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [ELEMENT_WIDTH-1:0] elem_r0c0,
	input  logic signed [ELEMENT_WIDTH-1:0] elem_r0c1,
	input  logic signed [ELEMENT_WIDTH-1:0] elem_r0c2,
	input  logic signed [ELEMENT_WIDTH-1:0] elem_r1c0,
	input  logic signed [ELEMENT_WIDTH-1:0] elem_r1c1,
	input  logic signed [ELEMENT_WIDTH-1:0] elem_r1c2,
	input  logic signed [ELEMENT_WIDTH-1:0] elem_r2c0,
	input  logic signed [ELEMENT_WIDTH-1:0] elem_r2c1,
	input  logic signed [ELEMENT_WIDTH-1:0] elem_r2c2,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [ELEMENT_WIDTH-1:0] inv_r0c0,
	output logic signed [ELEMENT_WIDTH-1:0] inv_r0c1,
	output logic signed [ELEMENT_WIDTH-1:0] inv_r0c2,
	output logic signed [ELEMENT_WIDTH-1:0] inv_r1c0,
	output logic signed [ELEMENT_WIDTH-1:0] inv_r1c1,
	output logic signed [ELEMENT_WIDTH-1:0] inv_r1c2,
	output logic signed [ELEMENT_WIDTH-1:0] inv_r2c0,
	output logic signed [ELEMENT_WIDTH-1:0] inv_r2c1,
	output logic signed [ELEMENT_WIDTH-1:0] inv_r2c2,
	output logic signed [ELEMENT_WIDTH-1:0] determinant,
	output logic singular
);
	import m3inv_pkg::*;

	localparam int W   = ELEMENT_WIDTH;
	localparam int F   = FRACTION_BITS;
	localparam int PW  = 2 * W;          // element product
	localparam int CW  = 2 * W + 1;      // cofactor, signed
	localparam int CM  = CW;             // cofactor magnitude
	localparam int TW  = 3 * W + 2;      // one determinant term
	localparam int DW  = 3 * W + 4;      // determinant, signed
	localparam int DM  = 3 * W + 3;      // determinant magnitude
	localparam int NW  = CM + 2 * F;     // rescaled numerator
	localparam int DSW = DM + W;
	localparam int RW  = ((NW > DSW) ? NW : DSW) + 1;
	localparam int NST = W + 8;

	localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic [DW-1:0] DLIM = DW'(1) << (W - 1);

	// per-stage valid and advance
	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;

	always_comb begin
		adv[NST-1] = !vld_q[NST-1] || !out_stall;
		for (int k = NST - 2; k >= 0; k--)
			adv[k] = !vld_q[k] || adv[k+1];
	end

	assign in_stall  = !adv[0];
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < NST; k++)
				if (adv[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	logic signed [W-1:0] el [NUM_ELEMS];
	assign el[0] = elem_r0c0;
	assign el[1] = elem_r0c1;
	assign el[2] = elem_r0c2;
	assign el[3] = elem_r1c0;
	assign el[4] = elem_r1c1;
	assign el[5] = elem_r1c2;
	assign el[6] = elem_r2c0;
	assign el[7] = elem_r2c1;
	assign el[8] = elem_r2c2;

	logic signed [PW-1:0] p1_s1 [NUM_ELEMS];
	logic signed [PW-1:0] p2_s1 [NUM_ELEMS];
	logic signed [W-1:0]  e0_s1 [MAT_DIM];
	logic signed [CW-1:0] cof_s2 [NUM_ELEMS];
	logic signed [W-1:0]  e0_s2 [MAT_DIM];
	logic signed [CW-1:0] cof_s3 [NUM_ELEMS];
	logic signed [CW-1:0] cof_s4 [NUM_ELEMS];
	logic signed [CW-1:0] cof_s5 [NUM_ELEMS];
	logic signed [2*W:0]  ppl_s3 [MAT_DIM];
	logic signed [2*W:0]  pph_s3 [MAT_DIM];
	logic signed [TW-1:0] term_s4 [MAT_DIM];
	logic signed [DW-1:0] det_s5;

	// division carry: index j holds stage 7+j (j = 0 is the overflow check)
	logic [CM-1:0] cmag_s6 [NUM_ELEMS];
	logic          cneg_s6 [NUM_ELEMS];
	logic [DM-1:0] dmag_s6;
	logic          dneg_s6;
	logic          sing_s6;
	logic [W-1:0]  dout_s6;

	logic [RW-1:0] rem_s7  [W+1][NUM_ELEMS];
	logic [W-1:0]  quo_s7  [W+1][NUM_ELEMS];
	logic          ovf_s7  [W+1][NUM_ELEMS];
	logic          cneg_s7 [W+1][NUM_ELEMS];
	logic [DM-1:0] dmag_s7 [W+1];
	logic          dneg_s7 [W+1];
	logic          sing_s7 [W+1];
	logic [W-1:0]  dout_s7 [W+1];

	logic [W-1:0] res_sout [NUM_ELEMS];
	logic [W-1:0] det_sout;
	logic         sing_sout;

	// cofactors, sign included (adjugate order)
	for (genvar g = 0; g < NUM_ELEMS; g++) begin : g_cof
		localparam int ROW = g / MAT_DIM;
		localparam int COL = g % MAT_DIM;
		localparam int R1  = (COL + 1) % MAT_DIM;
		localparam int R2  = (COL + 2) % MAT_DIM;
		localparam int C1  = (ROW + 1) % MAT_DIM;
		localparam int C2  = (ROW + 2) % MAT_DIM;

		logic [CW-1:0] cabs;
		assign cabs = cof_s5[g][CW-1] ? -cof_s5[g] : cof_s5[g];

		always_ff @(posedge clk) begin
			if (adv[0]) begin
				p1_s1[g] <= el[R1*MAT_DIM+C1] * el[R2*MAT_DIM+C2];
				p2_s1[g] <= el[R1*MAT_DIM+C2] * el[R2*MAT_DIM+C1];
			end
			if (adv[1])
				cof_s2[g] <= CW'(p1_s1[g]) - CW'(p2_s1[g]);
			if (adv[2])
				cof_s3[g] <= cof_s2[g];
			if (adv[3])
				cof_s4[g] <= cof_s3[g];
			if (adv[4])
				cof_s5[g] <= cof_s4[g];
			if (adv[5]) begin
				cmag_s6[g] <= cabs;
				cneg_s6[g] <= cof_s5[g][CW-1];
			end
		end
	end

	// determinant by first-row expansion, cofactor split into halves
	for (genvar k = 0; k < MAT_DIM; k++) begin : g_det
		logic signed [W:0] lo_u;
		assign lo_u = $signed({1'b0, cof_s2[k*MAT_DIM][W-1:0]});

		always_ff @(posedge clk) begin
			if (adv[0])
				e0_s1[k] <= el[k];
			if (adv[1])
				e0_s2[k] <= e0_s1[k];
			if (adv[2]) begin
				ppl_s3[k] <= e0_s2[k] * lo_u;
				pph_s3[k] <= e0_s2[k] * $signed(cof_s2[k*MAT_DIM][CW-1:W]);
			end
			if (adv[3])
				term_s4[k] <= (TW'(pph_s3[k]) <<< W) + TW'(ppl_s3[k]);
		end
	end

	logic [DW-1:0] dabs;
	logic [DW-1:0] dtr;
	logic [W-1:0]  dtr_lo;
	logic [W-1:0]  dsat;

	assign dabs   = det_s5[DW-1] ? -det_s5 : det_s5;
	assign dtr    = dabs >> (2 * F);
	assign dtr_lo = dtr[W-1:0];

	// determinant output: truncate toward zero, then saturate
	always_comb begin
		if (det_s5[DW-1])
			dsat = (dtr > DLIM) ? MINV : -dtr_lo;
		else
			dsat = (dtr >= DLIM) ? MAXV : dtr_lo;
	end

	always_ff @(posedge clk) begin
		if (adv[4])
			det_s5 <= DW'(term_s4[0]) + DW'(term_s4[1]) + DW'(term_s4[2]);
		if (adv[5]) begin
			dmag_s6 <= dabs[DM-1:0];
			dneg_s6 <= det_s5[DW-1];
			sing_s6 <= (det_s5 == '0);
			dout_s6 <= dsat;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar j = 0; j <= W; j++) begin : g_div
		if (j == 0) begin : g_first
			logic [RW-1:0] dlim;
			assign dlim = RW'(dmag_s6) << W;

			always_ff @(posedge clk) begin
				if (adv[6]) begin
					for (int g = 0; g < NUM_ELEMS; g++) begin
						rem_s7[0][g]  <= RW'(cmag_s6[g]) << (2 * F);
						ovf_s7[0][g]  <= (RW'(cmag_s6[g]) << (2 * F)) >= dlim;
						quo_s7[0][g]  <= '0;
						cneg_s7[0][g] <= cneg_s6[g];
					end
					dmag_s7[0] <= dmag_s6;
					dneg_s7[0] <= dneg_s6;
					sing_s7[0] <= sing_s6;
					dout_s7[0] <= dout_s6;
				end
			end
		end else begin : g_step
			logic [RW-1:0] dsh;
			assign dsh = RW'(dmag_s7[j-1]) << (W - j);

			always_ff @(posedge clk) begin
				if (adv[6+j]) begin
					for (int g = 0; g < NUM_ELEMS; g++) begin
						if (rem_s7[j-1][g] >= dsh) begin
							rem_s7[j][g] <= rem_s7[j-1][g] - dsh;
							quo_s7[j][g] <= {quo_s7[j-1][g][W-2:0], 1'b1};
						end else begin
							rem_s7[j][g] <= rem_s7[j-1][g];
							quo_s7[j][g] <= {quo_s7[j-1][g][W-2:0], 1'b0};
						end
						ovf_s7[j][g]  <= ovf_s7[j-1][g];
						cneg_s7[j][g] <= cneg_s7[j-1][g];
					end
					dmag_s7[j] <= dmag_s7[j-1];
					dneg_s7[j] <= dneg_s7[j-1];
					sing_s7[j] <= sing_s7[j-1];
					dout_s7[j] <= dout_s7[j-1];
				end
			end
		end
	end

	// sign, saturation and singular override
	for (genvar g = 0; g < NUM_ELEMS; g++) begin : g_out
		logic [W-1:0] qv;
		logic         neg;
		logic [W-1:0] val;

		assign qv  = quo_s7[W][g];
		assign neg = cneg_s7[W][g] ^ dneg_s7[W];

		always_comb begin
			if (sing_s7[W])
				val = '0;
			else if (neg)
				val = (ovf_s7[W][g] || qv > MINV) ? MINV : -qv;
			else
				val = (ovf_s7[W][g] || qv[W-1]) ? MAXV : qv;
		end

		always_ff @(posedge clk) begin
			if (adv[NST-1])
				res_sout[g] <= val;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NST-1]) begin
			det_sout  <= sing_s7[W] ? '0 : dout_s7[W];
			sing_sout <= sing_s7[W];
		end
	end

	assign inv_r0c0    = res_sout[0];
	assign inv_r0c1    = res_sout[1];
	assign inv_r0c2    = res_sout[2];
	assign inv_r1c0    = res_sout[3];
	assign inv_r1c1    = res_sout[4];
	assign inv_r1c2    = res_sout[5];
	assign inv_r2c0    = res_sout[6];
	assign inv_r2c1    = res_sout[7];
	assign inv_r2c2    = res_sout[8];
	assign determinant = det_sout;
	assign singular    = sing_sout;

	`M3INV_ASSERT_IMP(a_sing_zero, out_valid && singular, determinant == '0 && inv_r1c1 == '0, "singular result not zeroed")
	`M3INV_ASSERT_NXT(a_in_enters, in_valid && !in_stall, vld_q[0], "accepted transfer lost at entry")
	`M3INV_ASSERT_NXT(a_out_held, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule

[tb/sv/matrix3x3_inverse_unit_tb.sv]
// Testbench for matrix3x3_inverse_unit: directed table then random matrices, each result
// checked against an exact wide-integer adjugate/determinant model or a typed-in table value.
// Depends on m3inv_pkg and the matrix3x3_inverse_unit RTL.
module matrix3x3_inverse_unit_tb;
	import m3inv_pkg::*;

	localparam int EW = 32;
	localparam int FB = 16;
	localparam int LATENCY = EW + 8;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1100;

	typedef logic signed [159:0] wide_t;
	typedef logic [NUM_ELEMS-1:0][EW-1:0] mat_t;
	typedef struct packed {
		logic [9:0][EW-1:0] v;   // nine inverse entries, then determinant
		logic               sing;
	} inv_res_t;
	typedef struct packed {
		mat_t     m;
		logic     typed;
		inv_res_t r;
	} stim_row_t;

	localparam wide_t W_MAX = (wide_t'(1) <<< (EW - 1)) - 1;
	localparam wide_t W_MIN = -(wide_t'(1) <<< (EW - 1));
	localparam logic [EW-1:0] E_MAX = {1'b0, {(EW-1){1'b1}}};
	localparam logic [EW-1:0] E_MIN = {1'b1, {(EW-1){1'b0}}};
	localparam logic [EW-1:0] ONE = 32'h0001_0000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_stall, out_valid, singular;
	logic out_stall = 1'b0;
	logic signed [EW-1:0] elem [NUM_ELEMS];
	logic signed [EW-1:0] inv [NUM_ELEMS];
	logic signed [EW-1:0] determinant;

	inv_res_t expected_q[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit calm = 0;

	always #1 clk = ~clk;

	matrix3x3_inverse_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.elem_r0c0(elem[0]), .elem_r0c1(elem[1]), .elem_r0c2(elem[2]),
		.elem_r1c0(elem[3]), .elem_r1c1(elem[4]), .elem_r1c2(elem[5]),
		.elem_r2c0(elem[6]), .elem_r2c1(elem[7]), .elem_r2c2(elem[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.inv_r0c0(inv[0]), .inv_r0c1(inv[1]), .inv_r0c2(inv[2]),
		.inv_r1c0(inv[3]), .inv_r1c1(inv[4]), .inv_r1c2(inv[5]),
		.inv_r2c0(inv[6]), .inv_r2c1(inv[7]), .inv_r2c2(inv[8]),
		.determinant(determinant), .singular(singular)
	);

	function automatic logic [EW-1:0] saturate(wide_t x);
		if (x > W_MAX) return E_MAX;
		if (x < W_MIN) return E_MIN;
		return x[EW-1:0];
	endfunction

	// exact adjugate over determinant, truncated toward zero
	function automatic inv_res_t invert(mat_t m);
		wide_t e [3][3];
		wide_t cof [3][3];
		wide_t det;
		inv_res_t r;
		int r1, r2, c1, c2;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				e[i][j] = wide_t'($signed(m[i*3+j]));
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				r1 = (j + 1) % 3; r2 = (j + 2) % 3;
				c1 = (i + 1) % 3; c2 = (i + 2) % 3;
				cof[i][j] = e[r1][c1] * e[r2][c2] - e[r1][c2] * e[r2][c1];
			end
		det = e[0][0] * cof[0][0] + e[0][1] * cof[1][0] + e[0][2] * cof[2][0];
		r = '0;
		if (det == 0) begin
			r.sing = 1'b1;
			return r;
		end
		for (int k = 0; k < NUM_ELEMS; k++)
			r.v[k] = saturate((cof[k/3][k%3] <<< (2*FB)) / det);
		r.v[9] = saturate(det / (wide_t'(1) <<< (2*FB)));
		return r;
	endfunction

	function automatic inv_res_t diag_res(logic [EW-1:0] d, logic [EW-1:0] dt);
		inv_res_t r = '0;
		r.v[0] = d; r.v[4] = d; r.v[8] = d; r.v[9] = dt;
		return r;
	endfunction

	function automatic mat_t diag(logic [EW-1:0] d);
		mat_t m = '0;
		m[0] = d; m[4] = d; m[8] = d;
		return m;
	endfunction

	function automatic logic [EW-1:0] small_val();
		return EW'($urandom_range(0, 1 << 19)) - (1 << 18);
	endfunction

	function automatic logic [EW-1:0] corner_val();
		case ($urandom_range(0, 5))
			0: return E_MAX;
			1: return E_MIN;
			2: return ONE;
			3: return -ONE;
			4: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic mat_t random_matrix();
		mat_t m;
		int kind = $urandom_range(0, 9);
		for (int k = 0; k < NUM_ELEMS; k++)
			case (kind)
				0, 1, 2: m[k] = $urandom;
				8: m[k] = (k % 4 == 0) ? small_val() : EW'($urandom_range(0, 255)) - 128;
				9: m[k] = corner_val();
				default: m[k] = small_val();
			endcase
		if (kind == 7) begin
			// row 2 a copy of row 0, each entry optionally negated (singular if all or none are)
			for (int c = 0; c < 3; c++)
				m[6+c] = $urandom_range(0, 1) ? m[c] : -m[c];
		end
		return m;
	endfunction

	task automatic send(mat_t m, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		for (int k = 0; k < NUM_ELEMS; k++) elem[k] <= m[k];
		do @(posedge clk); while (in_stall);
		expected_q.push_back(invert(m));
	endtask

	function automatic int pick_gap();
		int r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver stall pattern
	int stall_run = 0;
	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0) calm <= ~calm;
		if (stall_run > 0) begin
			out_stall <= 1'b1;
			stall_run <= stall_run - 1;
		end else if (calm || $urandom_range(0, 99) < 65) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b1;
			stall_run <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 3);
		end
	end

	// result checker and watchdog
	always @(posedge clk) begin
		inv_res_t want, got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				for (int k = 0; k < NUM_ELEMS; k++) got.v[k] = inv[k];
				got.v[9] = determinant;
				got.sing = singular;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result transfer");
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							for (int k = 0; k < 10; k++)
								if (got.v[k] !== want.v[k])
									$display("field %0d: expected %h got %h",
										k, want.v[k], got.v[k]);
							if (got.sing !== want.sing)
								$display("singular: expected %b got %b",
									want.sing, got.sing);
						end
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	stim_row_t rows[$];

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		for (int k = 0; k < NUM_ELEMS; k++) elem[k] = '0;

		rows.push_back('{diag(ONE), 1'b1, diag_res(ONE, ONE)});
		rows.push_back('{mat_t'('0), 1'b1, inv_res_t'(1)});
		rows.push_back('{diag(2 * ONE), 1'b1, diag_res(ONE / 2, 8 * ONE)});
		rows.push_back('{diag(-ONE), 1'b1, diag_res(-ONE, -ONE)});
		rows.push_back('{{NUM_ELEMS{ONE}}, 1'b1, inv_res_t'(1)});     // rank one
		rows.push_back('{{NUM_ELEMS{E_MAX}}, 1'b1, inv_res_t'(1)});
		rows.push_back('{{NUM_ELEMS{E_MIN}}, 1'b1, inv_res_t'(1)});
		rows.push_back('{diag(E_MAX), 1'b0, '0});
		rows.push_back('{diag(E_MIN), 1'b0, '0});
		rows.push_back('{diag(1), 1'b0, '0});                        // tiny determinant
		rows.push_back('{diag(-1), 1'b0, '0});
		rows.push_back('{{E_MAX, E_MIN, E_MAX, E_MIN, E_MAX, E_MIN, E_MAX, E_MIN, E_MAX},
			1'b0, '0});
		rows.push_back('{{E_MIN, E_MAX, 32'd0, E_MAX, E_MIN, E_MAX, 32'd0, E_MAX, E_MIN},
			1'b0, '0});
		rows.push_back('{{32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, ONE, 32'd0, 32'd0},
			1'b0, '0});                                               // permutation
		rows.push_back('{{ONE, 32'd3, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1},
			1'b0, '0});
		rows.push_back('{{32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 32'h0,
			32'h0, 32'h0, 32'h7fff_ffff}, 1'b0, '0});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send(rows[i].m, pick_gap());
			// table values stand in for the model where typed in
			if (rows[i].typed) expected_q[$] = rows[i].r;
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				in_valid <= 1'b0;
				while (expected_q.size() != 0) @(posedge clk);
			end
			send(random_matrix(), pick_gap());
		end
		in_valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
